@@ rtl/core/kvat_pkg.sv @@
// Shared types and constants for the kernel virtual address translator.
`default_nettype none
package kvat_pkg;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned FrameW  = 20;
  localparam int unsigned OffsetW = 12;
  localparam int unsigned IndexW  = 10;
  localparam int unsigned PaddrW  = 4;

  // Register map, one 32-bit register per word.
  localparam logic [1:0] REG_KERNEL_BASE   = 2'd0;
  localparam logic [1:0] REG_HIGH_MEM      = 2'd1;
  localparam logic [1:0] REG_KMAP_BASE     = 2'd2;
  localparam logic [1:0] REG_DIR_POINTER   = 2'd3;

  localparam logic [AddrW-1:0] KERNEL_BASE_RST = 32'hC000_0000;
  localparam logic [AddrW-1:0] HIGH_MEM_RST    = 32'hF800_0000;
  localparam logic [AddrW-1:0] KMAP_BASE_RST   = 32'hFE00_0000;
  localparam logic [AddrW-1:0] DIR_POINTER_RST = 32'h0000_0000;

  localparam logic [AddrW-1:0] FRAME_MASK = 32'hFFFF_F000;

  // Request actions.
  localparam logic ACT_TRANSLATE = 1'b0;
  localparam logic ACT_RESPONSE  = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_READ = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;

  // Address spaces.
  localparam logic SPACE_PHYS    = 1'b0;
  localparam logic SPACE_MACHINE = 1'b1;

  // Failure codes.
  localparam logic [2:0] FAIL_NONE       = 3'd0;
  localparam logic [2:0] FAIL_RANGE      = 3'd1;
  localparam logic [2:0] FAIL_READ       = 3'd2;
  localparam logic [2:0] FAIL_ZERO       = 3'd3;
  localparam logic [2:0] FAIL_UNEXPECTED = 3'd4;

  // Walk phases.
  localparam logic [1:0] PHASE_IDLE  = 2'd0;
  localparam logic [1:0] PHASE_DPTR  = 2'd1;
  localparam logic [1:0] PHASE_DIR   = 2'd2;
  localparam logic [1:0] PHASE_TABLE = 2'd3;

  typedef struct packed {
    logic [AddrW-1:0] kernel_base;
    logic [AddrW-1:0] high_memory_limit;
    logic [AddrW-1:0] kmap_base;
    logic [AddrW-1:0] directory_pointer_address;
  } cfg_t;

  typedef struct packed {
    logic             action;
    logic [AddrW-1:0] virtual_address;
    logic [AddrW-1:0] read_data;
    logic             read_fault;
  } req_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic               address_space;
    logic [FrameW-1:0]  frame_number;
    logic [OffsetW-1:0] byte_offset;
    logic [2:0]         fail_code;
  } rsp_t;

endpackage
`default_nettype wire

@@ rtl/core/kvat_channels.sv @@
// Valid/ready channel interfaces for translator requests and results.
`default_nettype none
interface kvat_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] virtual_address;
  logic [31:0] read_data;
  logic        read_fault;

  modport source (output valid, action, virtual_address, read_data, read_fault,
                  input ready);
  modport sink   (input valid, action, virtual_address, read_data, read_fault,
                  output ready);
endinterface

interface kvat_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic        address_space;
  logic [19:0] frame_number;
  logic [11:0] byte_offset;
  logic [2:0]  fail_code;

  modport source (output valid, result_kind, address_space, frame_number, byte_offset,
                  fail_code, input ready);
  modport sink   (input valid, result_kind, address_space, frame_number, byte_offset,
                  fail_code, output ready);
endinterface
`default_nettype wire

@@ rtl/core/kvat_cfg_regs.sv @@
// APB configuration register bank for the translator.
`default_nettype none
module kvat_cfg_regs
  import kvat_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[PaddrW-1:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kernel_base               <= KERNEL_BASE_RST;
      cfg.high_memory_limit         <= HIGH_MEM_RST;
      cfg.kmap_base                 <= KMAP_BASE_RST;
      cfg.directory_pointer_address <= DIR_POINTER_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_KERNEL_BASE: cfg.kernel_base               <= pwdata;
        REG_HIGH_MEM:    cfg.high_memory_limit         <= pwdata;
        REG_KMAP_BASE:   cfg.kmap_base                 <= pwdata;
        REG_DIR_POINTER: cfg.directory_pointer_address <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_KERNEL_BASE: prdata = cfg.kernel_base;
      REG_HIGH_MEM:    prdata = cfg.high_memory_limit;
      REG_KMAP_BASE:   prdata = cfg.kmap_base;
      REG_DIR_POINTER: prdata = cfg.directory_pointer_address;
      default:         prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/kvat_walk.sv @@
// Per-request translation step and page-walk state registers.
`default_nettype none
module kvat_walk
  import kvat_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic advance,
  input  wire cfg_t cfg,
  input  wire req_t req,
  output rsp_t      rsp
);

  logic [1:0]       walk_phase;
  logic [1:0]       walk_phase_next;
  logic [AddrW-1:0] held_address;
  logic [AddrW-1:0] held_address_next;

  logic [AddrW-1:0] va;
  logic [AddrW-1:0] dir_ptr;
  logic [AddrW-1:0] table_ptr;
  logic [AddrW-1:0] final_addr;
  logic [AddrW-1:0] out_addr;
  logic             in_linear;
  logic             in_walked;

  assign va        = req.virtual_address;
  assign in_linear = (cfg.kernel_base < va) && (va < cfg.high_memory_limit);
  assign in_walked = (cfg.high_memory_limit < va) && (va < cfg.kmap_base);

  // Directory entry address: base word plus 4 * directory index.
  assign dir_ptr    = req.read_data + {20'd0, held_address[31:22], 2'b00};
  // Table entry address: frame of directory entry plus 4 * table index.
  assign table_ptr  = (req.read_data & FRAME_MASK) + {20'd0, held_address[21:12], 2'b00};
  assign final_addr = (req.read_data & FRAME_MASK) + {20'd0, held_address[11:0]};

  always_comb begin
    walk_phase_next   = walk_phase;
    held_address_next = held_address;
    rsp.result_kind   = KIND_FAIL;
    rsp.address_space = SPACE_PHYS;
    rsp.fail_code     = FAIL_NONE;
    out_addr          = '0;
    if (req.action == ACT_TRANSLATE) begin
      walk_phase_next = PHASE_IDLE;
      if (in_linear) begin
        rsp.result_kind = KIND_DONE;
        out_addr        = va - cfg.kernel_base;
      end else if (in_walked) begin
        held_address_next = va;
        walk_phase_next   = PHASE_DPTR;
        rsp.result_kind   = KIND_READ;
        out_addr          = cfg.directory_pointer_address - cfg.kernel_base;
      end else begin
        rsp.fail_code = FAIL_RANGE;
      end
    end else if (walk_phase == PHASE_IDLE) begin
      rsp.fail_code = FAIL_UNEXPECTED;
    end else if (req.read_fault) begin
      walk_phase_next = PHASE_IDLE;
      rsp.fail_code   = FAIL_READ;
    end else begin
      unique case (walk_phase)
        PHASE_DPTR: begin
          walk_phase_next = PHASE_DIR;
          rsp.result_kind = KIND_READ;
          out_addr        = dir_ptr - cfg.kernel_base;
        end
        PHASE_DIR: begin
          walk_phase_next   = PHASE_TABLE;
          rsp.result_kind   = KIND_READ;
          rsp.address_space = SPACE_MACHINE;
          out_addr          = table_ptr;
        end
        default: begin
          walk_phase_next = PHASE_IDLE;
          if (final_addr == '0) begin
            rsp.fail_code = FAIL_ZERO;
          end else begin
            rsp.result_kind   = KIND_DONE;
            rsp.address_space = SPACE_MACHINE;
            out_addr          = final_addr;
          end
        end
      endcase
    end
    rsp.frame_number = out_addr[AddrW-1:OffsetW];
    rsp.byte_offset  = out_addr[OffsetW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_phase   <= PHASE_IDLE;
      held_address <= '0;
    end else if (advance) begin
      walk_phase   <= walk_phase_next;
      held_address <= held_address_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/kernel_virtual_address_translator.sv @@
// Kernel virtual address translator: linear map plus two-level page-walk sequencing.
// A request passes through an input register, then a result register; a stalled result holds
// it in the input register. Throughput: one request per cycle while results are taken; the
// walk state advances as each request leaves the input register, so a memory response may
// follow its read request back to back.
// Reset (rst, synchronous): both pipeline registers empty, walk idle, config at default values.
`default_nettype none
module kernel_virtual_address_translator
  import kvat_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // APB configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  // Channels
  kvat_req_if.sink               request,
  kvat_rsp_if.source             result
);

  cfg_t cfg;
  req_t in_item;
  rsp_t step_rsp;
  rsp_t out_item;
  logic in_valid;
  logic out_valid;
  logic advance;

  kvat_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Move the held request into the result register when that slot is free or draining.
  assign advance       = in_valid & (~out_valid | result.ready);
  // Take a new request whenever the input register empties this cycle.
  assign request.ready = ~in_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (request.ready) begin
      in_valid <= request.valid;
    end
  end

  // Payload needs no reset; capture on every accepted request.
  always_ff @(posedge clk) begin
    if (request.valid & request.ready) begin
      in_item.action          <= request.action;
      in_item.virtual_address <= request.virtual_address;
      in_item.read_data       <= request.read_data;
      in_item.read_fault      <= request.read_fault;
    end
  end

  // Single-pass translate step; walk state updates only when the request advances.
  kvat_walk u_walk (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .cfg     (cfg),
    .req     (in_item),
    .rsp     (step_rsp)
  );

  // Result register: hold until taken, refill in the same cycle if another request advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= step_rsp;
    end
  end

  assign result.valid         = out_valid;
  assign result.result_kind   = out_item.result_kind;
  assign result.address_space = out_item.address_space;
  assign result.frame_number  = out_item.frame_number;
  assign result.byte_offset   = out_item.byte_offset;
  assign result.fail_code     = out_item.fail_code;

endmodule
`default_nettype wire

@@ bench/kernel_virtual_address_translator_tb.sv @@
// Self-checking testbench for the kernel virtual address translator.
module kernel_virtual_address_translator_tb;
  import kvat_pkg::*;

  localparam int HOLDOFF_CYCLES   = 200;   // long result stall that backs up the pipeline
  localparam int STALL_LIMIT      = 2000;  // cycles with no traffic before giving up
  localparam int SHOWN_MISMATCHES = 10;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  kvat_req_if req_ch ();
  kvat_rsp_if rsp_ch ();

  kernel_virtual_address_translator DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .request (req_ch),
    .result  (rsp_ch)
  );

  // Bench copy of the register file, updated as each write lands.
  logic [31:0] cfg_kernel_base = KERNEL_BASE_RST;
  logic [31:0] cfg_high_mem    = HIGH_MEM_RST;
  logic [31:0] cfg_kmap_base   = KMAP_BASE_RST;
  logic [31:0] cfg_dir_pointer = DIR_POINTER_RST;

  // Bench copy of the walk state.
  logic [1:0]  walk_phase = PHASE_IDLE;
  logic [31:0] held_va    = '0;
  logic [31:0] walk_ptr   = '0;

  // Translations, read requests and failures predicted but not yet seen on the result channel.
  rsp_t awaited_results[$];

  int items_sent     = 0;
  int items_accepted = 0;
  int results_seen   = 0;
  int errors         = 0;
  int settings_used  = 0;
  int quiet_cycles   = 0;
  int kind_count[3]  = '{0, 0, 0};
  int fail_count[5]  = '{0, 0, 0, 0, 0};

  bit idling_on       = 1'b1;
  bit holdoff_pending = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Compute the one result a request causes and advance the walk state.
  function automatic rsp_t predict_translation(req_t r);
    rsp_t        o;
    logic [31:0] final_addr;
    o = '0;
    if (r.action == ACT_TRANSLATE) begin
      walk_phase = PHASE_IDLE;
      if (cfg_kernel_base < r.virtual_address && r.virtual_address < cfg_high_mem) begin
        // Linear region: physical is a plain subtract, wrapping.
        o.result_kind = KIND_DONE;
        {o.frame_number, o.byte_offset} = r.virtual_address - cfg_kernel_base;
      end else if (cfg_high_mem < r.virtual_address && r.virtual_address < cfg_kmap_base) begin
        // Walked region: first fetch the directory base.
        held_va     = r.virtual_address;
        walk_phase  = PHASE_DPTR;
        o.result_kind = KIND_READ;
        {o.frame_number, o.byte_offset} = cfg_dir_pointer - cfg_kernel_base;
      end else begin
        o.result_kind = KIND_FAIL;
        o.fail_code   = FAIL_RANGE;
      end
    end else if (walk_phase == PHASE_IDLE) begin
      o.result_kind = KIND_FAIL;
      o.fail_code   = FAIL_UNEXPECTED;
    end else if (r.read_fault) begin
      walk_phase    = PHASE_IDLE;
      o.result_kind = KIND_FAIL;
      o.fail_code   = FAIL_READ;
    end else begin
      case (walk_phase)
        PHASE_DPTR: begin
          walk_ptr      = r.read_data + 32'({held_va[31:22], 2'b00});
          walk_phase    = PHASE_DIR;
          o.result_kind = KIND_READ;
          {o.frame_number, o.byte_offset} = walk_ptr - cfg_kernel_base;
        end
        PHASE_DIR: begin
          walk_ptr        = (r.read_data & FRAME_MASK) + 32'({held_va[21:12], 2'b00});
          walk_phase      = PHASE_TABLE;
          o.result_kind   = KIND_READ;
          o.address_space = SPACE_MACHINE;
          {o.frame_number, o.byte_offset} = walk_ptr;
        end
        default: begin
          final_addr = (r.read_data & FRAME_MASK) + 32'(held_va[11:0]);
          walk_phase = PHASE_IDLE;
          if (final_addr == 0) begin
            o.result_kind = KIND_FAIL;
            o.fail_code   = FAIL_ZERO;
          end else begin
            o.result_kind   = KIND_DONE;
            o.address_space = SPACE_MACHINE;
            {o.frame_number, o.byte_offset} = final_addr;
          end
        end
      endcase
    end
    kind_count[o.result_kind]++;
    if (o.result_kind == KIND_FAIL) fail_count[o.fail_code]++;
    return o;
  endfunction

  task automatic report_result(string what, rsp_t want, rsp_t got);
    errors++;
    if (errors <= SHOWN_MISMATCHES)
      $display("%0t %s: expected kind %0d space %0d frame %05h offset %03h code %0d,",
               $time, what, want.result_kind, want.address_space, want.frame_number,
               want.byte_offset, want.fail_code,
               " got kind %0d space %0d frame %05h offset %03h code %0d",
               got.result_kind, got.address_space, got.frame_number, got.byte_offset,
               got.fail_code);
  endtask

  // Check each result against the oldest prediction, then predict for each accepted request.
  // Both handshakes are sampled at the edge, before any input driven at that edge lands.
  always @(posedge clk) begin : result_checker
    rsp_t got;
    rsp_t want;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = {rsp_ch.result_kind, rsp_ch.address_space, rsp_ch.frame_number,
               rsp_ch.byte_offset, rsp_ch.fail_code};
        results_seen++;
        if (awaited_results.size() == 0) begin
          report_result("result with nothing pending", '0, got);
        end else begin
          want = awaited_results.pop_front();
          if (got.result_kind !== want.result_kind || got.address_space !== want.address_space ||
              got.frame_number !== want.frame_number || got.byte_offset !== want.byte_offset ||
              got.fail_code !== want.fail_code)
            report_result("result mismatch", want, got);
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        items_accepted++;
        awaited_results.push_back(predict_translation({req_ch.action, req_ch.virtual_address,
                                                       req_ch.read_data, req_ch.read_fault}));
      end
    end
  end

  // Give up when neither channel nor the register port has moved for too long.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t no traffic for %0d cycles, %0d results outstanding", $time,
                 quiet_cycles, awaited_results.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Result side: hold ready in random bursts, or for one long stretch when asked.
  // Each pass drives ready once and then holds it for the chosen number of cycles.
  initial begin : result_sink
    int stall;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_pending) begin
        holdoff_pending = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLDOFF_CYCLES - 1) @(posedge clk);
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        rsp_ch.ready <= 1'b0;
        stall = $urandom_range(1, 15);
        repeat (stall - 1) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one request, optionally after an idle burst, and hold until it is taken.
  // Valid is left high on return so that a following request goes out back to back.
  task automatic send_request(req_t r);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    req_ch.valid           <= 1'b1;
    req_ch.action          <= r.action;
    req_ch.virtual_address <= r.virtual_address;
    req_ch.read_data       <= r.read_data;
    req_ch.read_fault      <= r.read_fault;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
  endtask

  // Unused fields get random values so their bits toggle too.
  task automatic translate(logic [31:0] va);
    req_t r;
    r.action          = ACT_TRANSLATE;
    r.virtual_address = va;
    r.read_data       = $urandom;
    r.read_fault      = 1'($urandom);
    send_request(r);
  endtask

  task automatic respond(logic [31:0] data, logic fault);
    req_t r;
    r.action          = ACT_RESPONSE;
    r.virtual_address = $urandom;
    r.read_data       = data;
    r.read_fault      = fault;
    send_request(r);
  endtask

  // Drop valid and wait until every predicted result has come, plus the pipeline depth.
  // Wait for a clock edge first so the prediction for the last accepted request is queued.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Two-phase register write; psel is left up so writes can follow each other.
  task automatic write_register(logic [1:0] index, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'({index, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (index)
      REG_KERNEL_BASE: cfg_kernel_base = value;
      REG_HIGH_MEM:    cfg_high_mem    = value;
      REG_KMAP_BASE:   cfg_kmap_base   = value;
      default:         cfg_dir_pointer = value;
    endcase
  endtask

  task automatic load_settings(logic [31:0] kb, logic [31:0] hm, logic [31:0] km,
                               logic [31:0] dp);
    drain_results();
    write_register(REG_KERNEL_BASE, kb);
    write_register(REG_HIGH_MEM, hm);
    write_register(REG_KMAP_BASE, km);
    write_register(REG_DIR_POINTER, dp);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // Random address strictly inside (lo, hi), or anywhere when that range is empty.
  function automatic logic [31:0] pick_between(logic [31:0] lo, logic [31:0] hi);
    if ({1'b0, hi} > {1'b0, lo} + 33'd1) return $urandom_range(hi - 1, lo + 1);
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_translate_address();
    logic [31:0] marks [11];
    marks = '{cfg_kernel_base - 1, cfg_kernel_base, cfg_kernel_base + 1,
              cfg_high_mem - 1, cfg_high_mem, cfg_high_mem + 1,
              cfg_kmap_base - 1, cfg_kmap_base, cfg_kmap_base + 1,
              32'h0000_0000, 32'hFFFF_FFFF};
    case ($urandom_range(0, 3))
      0:       return marks[$urandom_range(0, 10)];
      1:       return pick_between(cfg_kernel_base, cfg_high_mem);
      2:       return pick_between(cfg_high_mem, cfg_kmap_base);
      default: return $urandom;
    endcase
  endfunction

  // One page walk with random memory contents; now and then abandon it, fault a read,
  // or return a table entry whose frame is zero.
  task automatic walk_sequence();
    logic [31:0] va;
    logic [31:0] page_va;
    logic [31:0] data;
    logic        fault;
    int          roll;
    va      = pick_between(cfg_high_mem, cfg_kmap_base);
    page_va = {va[31:12], 12'h000};
    if ($urandom_range(0, 5) == 0 && cfg_high_mem < page_va && page_va < cfg_kmap_base)
      va = page_va;
    translate(va);
    for (int step = 0; step < 3; step++) begin
      roll = $urandom_range(0, 19);
      if (roll == 0) begin
        translate(pick_translate_address());
        break;
      end
      fault = (roll == 1);
      data  = $urandom;
      if (step == 2 && $urandom_range(0, 5) == 0) data[31:12] = '0;
      respond(data, fault);
      if (fault) break;
    end
  endtask

  // Page walks for half of the picks, with linear and boundary translates and stray requests mixed in.
  task automatic run_random_mix(int stop_at);
    req_t noise;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 7))
        0, 1, 2, 3: walk_sequence();
        4, 5:       translate(pick_translate_address());
        default: begin
          noise = {1'($urandom), 32'($urandom), 32'($urandom), 1'($urandom)};
          send_request(noise);
        end
      endcase
    end
  endtask

  // Region bounds, abandoned walks, stray responses, faults and a zero final address,
  // all under the reset register values.
  task automatic test_directed_cases();
    translate(cfg_kernel_base);             // bound itself is unmapped
    translate(cfg_kernel_base + 1);
    translate(cfg_high_mem - 1);
    translate(cfg_high_mem);
    translate(cfg_kmap_base - 1);           // starts a walk
    translate(cfg_kmap_base);               // abandons it and fails
    translate(32'h0000_0000);
    translate(32'hFFFF_FFFF);
    respond($urandom, 1'b0);                // nothing pending
    translate(cfg_high_mem + 1);
    respond(32'hFFFF_FFFF, 1'b0);           // pointer sum wraps
    respond(32'h0123_4567, 1'b0);
    respond(32'h89AB_CDEF, 1'b0);
    translate(32'hF840_0000);
    respond($urandom, 1'b0);
    respond($urandom, 1'b0);
    respond(32'h0000_0FFF, 1'b0);           // frame and offset both zero
    translate(cfg_kmap_base - 1);
    respond($urandom, 1'b1);                // fault on the directory pointer
    translate(cfg_high_mem + 1);
    respond($urandom, 1'b0);
    respond($urandom, 1'b1);                // fault on the directory entry
    translate(cfg_high_mem + 1);
    respond($urandom, 1'b0);
    translate(cfg_kernel_base + 1);         // new request mid-walk
  endtask

  task automatic test_random_default_settings();
    run_random_mix(items_sent + 100);
  endtask

  // Stall results long enough that the block fills and stops taking requests.
  task automatic test_result_backpressure();
    drain_results();
    holdoff_pending = 1'b1;
    run_random_mix(items_sent + 30);
  endtask

  // Pause the request side until everything outstanding has come back.
  task automatic test_sender_pause();
    run_random_mix(items_sent + 10);
    drain_results();
    run_random_mix(items_sent + 10);
  endtask

  task automatic test_register_settings();
    load_settings(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    run_random_mix(items_sent + 30);
    load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random_mix(items_sent + 30);
    load_settings(32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFC);
    run_random_mix(items_sent + 30);
    // Narrow regions: one linear address, two walked ones.
    load_settings(32'h0000_1000, 32'h0000_1002, 32'h0000_1005, $urandom);
    run_random_mix(items_sent + 30);
    // Bounds out of order: the linear region is empty.
    load_settings(32'hF000_0000, 32'h1000_0000, 32'h8000_0000, 32'h1234_5678);
    run_random_mix(items_sent + 30);
    load_settings($urandom, $urandom, $urandom, $urandom);
    run_random_mix(items_sent + 30);
  endtask

  // Finish at full rate on both sides, back at the reset layout.
  task automatic test_back_to_back();
    idling_on = 1'b0;
    load_settings(KERNEL_BASE_RST, HIGH_MEM_RST, KMAP_BASE_RST, $urandom);
    run_random_mix(items_sent + 80);
  endtask

  initial begin
    rst                    <= 1'b1;
    psel                   <= 1'b0;
    penable                <= 1'b0;
    pwrite                 <= 1'b0;
    paddr                  <= '0;
    pwdata                 <= '0;
    req_ch.valid           <= 1'b0;
    req_ch.action          <= ACT_TRANSLATE;
    req_ch.virtual_address <= '0;
    req_ch.read_data       <= '0;
    req_ch.read_fault      <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_random_default_settings();
    test_result_backpressure();
    test_sender_pause();
    test_register_settings();
    test_back_to_back();
    drain_results();

    $display("Sent %0d requests and checked %0d results across %0d register layouts.",
             items_accepted, results_seen, settings_used + 1);
    $display("Reads %0d, translations %0d, failures: range %0d, fault %0d, zero %0d, stray %0d.",
             kind_count[KIND_READ], kind_count[KIND_DONE], fail_count[FAIL_RANGE],
             fail_count[FAIL_READ], fail_count[FAIL_ZERO], fail_count[FAIL_UNEXPECTED]);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
